FILE: hw/rtl/sfr_pkg.sv
// Shared types and constants for the SOF/length/XOR frame receiver.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package sfr_pkg;

   localparam int unsigned MAX_PAYLOAD_BYTES = 28;
   localparam int unsigned ADDR_W            = $clog2(MAX_PAYLOAD_BYTES);
   localparam int unsigned LEN_W             = 5;
   localparam int unsigned TIMER_W           = 18;
   localparam int unsigned CFG_W             = 16;

   localparam logic [7:0]         SOF_BYTE        = 8'hAA;
   localparam logic [7:0]         MAX_LEN_BYTE    = 8'(MAX_PAYLOAD_BYTES);
   localparam logic [TIMER_W-1:0] TIMER_MAX       = {TIMER_W{1'b1}};
   localparam logic [CFG_W-1:0]   CFG_RESET_TICKS = 16'd100;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_TIMEOUT  = 2'd1,
      STATUS_OVERFLOW = 2'd2,
      STATUS_CHKERR   = 2'd3
   } status_type;

   // Access bundle from the parser to the payload store.
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [7:0]        wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

endpackage

`default_nettype wire

FILE: hw/rtl/sfr_ifs.sv
// Handshake channel interfaces for the frame receiver: input items, results, CSR writes.
// Depends on sfr_pkg for field widths.
`default_nettype none

interface sfr_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] rx_byte;

   modport source (output valid, action, rx_byte, input ready);
   modport sink   (input valid, action, rx_byte, output ready);
endinterface

interface sfr_rsp_if;
   logic                     valid;
   logic                     ready;
   logic [1:0]               status;
   logic [sfr_pkg::LEN_W-1:0] frame_length;
   logic [7:0]               data_byte;
   logic                     byte_valid;
   logic                     last;

   modport source (output valid, status, frame_length, data_byte, byte_valid, last,
                   input ready);
   modport sink   (input valid, status, frame_length, data_byte, byte_valid, last,
                   output ready);
endinterface

interface sfr_csr_if;
   logic                      valid;
   logic                      ready;
   logic [sfr_pkg::CFG_W-1:0] wr_data;

   modport source (output valid, wr_data, input ready);
   modport sink   (input valid, wr_data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/sfr_store.sv
// Payload store: single write port, single read port, registered read data.
// Depends on sfr_pkg for the access bundle and depth.
`default_nettype none

module sfr_store (
   input  wire logic                 clock,
   input  wire sfr_pkg::mem_req_type mem_req,
   output logic [7:0]                rd_data
);
   import sfr_pkg::*;

   logic [7:0] mem [MAX_PAYLOAD_BYTES];
   logic [7:0] rd_data_ff;

   // Entries are undefined until written; only bytes of the current frame are read.
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/sfr_parser.sv
// Frame parser, timeout timer, payload release sequencer and result register.
// Depends on sfr_pkg and the channel interfaces; drives the payload store.
`default_nettype none

module sfr_parser (
   input  wire logic                        clock,
   input  wire logic                        reset,
   sfr_req_if.sink                          req,
   sfr_rsp_if.source                        rsp,
   input  wire logic [sfr_pkg::CFG_W-1:0]   timeout_ticks,
   output sfr_pkg::mem_req_type             mem_req,
   input  wire logic [7:0]                  mem_rd_data
);
   import sfr_pkg::*;

   typedef enum logic [3:0] {
      PH_HUNT = 4'b0001,
      PH_LEN  = 4'b0010,
      PH_DATA = 4'b0100,
      PH_CHK  = 4'b1000
   } phase_type;

   typedef enum logic [2:0] {
      CTL_ACCEPT = 3'b001,
      CTL_READ   = 3'b010,
      CTL_SEND   = 3'b100
   } ctl_type;

   phase_type          phase_ff, phase_in;
   ctl_type            ctl_ff, ctl_in;
   logic [LEN_W-1:0]   exp_len_ff, exp_len_in;
   logic [LEN_W-1:0]   count_ff, count_in;
   logic [7:0]         xor_ff, xor_in;
   logic [TIMER_W-1:0] timer_ff, timer_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;

   logic               out_valid_ff, out_valid_in;
   status_type         out_status_ff, out_status_in;
   logic [LEN_W-1:0]   out_len_ff, out_len_in;
   logic [7:0]         out_data_ff, out_data_in;
   logic               out_bvalid_ff, out_bvalid_in;
   logic               out_last_ff, out_last_in;

   logic               out_free;
   logic               accept;
   logic [TIMER_W-1:0] timer_sat;
   logic [TIMER_W-1:0] limit;
   logic [LEN_W-1:0]   count_inc;
   logic [LEN_W-1:0]   idx_inc;
   logic               load_out;

   assign out_free  = !out_valid_ff || rsp.ready;
   assign req.ready = (ctl_ff == CTL_ACCEPT) && out_free;
   assign accept    = req.valid && req.ready;

   assign timer_sat = (timer_ff == TIMER_MAX) ? timer_ff : timer_ff + 1'b1;
   assign limit     = (phase_ff == PH_DATA) ? {timer_ff[TIMER_W-1:TIMER_W-2] & 2'b00,
                                               timeout_ticks} << 2
                                            : {2'b00, timeout_ticks};
   assign count_inc = count_ff + 1'b1;
   assign idx_inc   = LEN_W'(idx_ff) + 1'b1;

   always_comb begin
      phase_in      = phase_ff;
      ctl_in        = ctl_ff;
      exp_len_in    = exp_len_ff;
      count_in      = count_ff;
      xor_in        = xor_ff;
      timer_in      = timer_ff;
      idx_in        = idx_ff;
      load_out      = 1'b0;
      out_status_in = out_status_ff;
      out_len_in    = out_len_ff;
      out_data_in   = out_data_ff;
      out_bvalid_in = out_bvalid_ff;
      out_last_in   = out_last_ff;
      mem_req       = '0;
      mem_req.wr_addr = count_ff[ADDR_W-1:0];
      mem_req.wr_data = req.rx_byte;
      mem_req.rd_addr = idx_ff;

      unique case (ctl_ff)
         CTL_ACCEPT: begin
            if (accept) begin
               if (req.action) begin
                  timer_in = timer_sat;
                  if (timer_sat >= limit) begin
                     load_out      = 1'b1;
                     out_status_in = STATUS_TIMEOUT;
                     phase_in      = PH_HUNT;
                     timer_in      = '0;
                  end
               end else begin
                  unique case (phase_ff)
                     PH_HUNT: begin
                        timer_in = '0;
                        if (req.rx_byte != SOF_BYTE) begin
                           load_out      = 1'b1;
                           out_status_in = STATUS_TIMEOUT;
                        end else begin
                           phase_in = PH_LEN;
                        end
                     end
                     PH_LEN: begin
                        timer_in = '0;
                        if (req.rx_byte > MAX_LEN_BYTE) begin
                           load_out      = 1'b1;
                           out_status_in = STATUS_OVERFLOW;
                           phase_in      = PH_HUNT;
                        end else begin
                           exp_len_in = req.rx_byte[LEN_W-1:0];
                           count_in   = '0;
                           xor_in     = '0;
                           phase_in   = (req.rx_byte == 8'd0) ? PH_CHK : PH_DATA;
                        end
                     end
                     PH_DATA: begin
                        mem_req.wr_en = 1'b1;
                        xor_in        = xor_ff ^ req.rx_byte;
                        count_in      = count_inc;
                        if (count_inc >= exp_len_ff) begin
                           phase_in = PH_CHK;
                           timer_in = '0;
                        end
                     end
                     PH_CHK: begin
                        phase_in = PH_HUNT;
                        timer_in = '0;
                        if (req.rx_byte != xor_ff) begin
                           load_out      = 1'b1;
                           out_status_in = STATUS_CHKERR;
                        end else if (exp_len_ff == '0) begin
                           load_out      = 1'b1;
                           out_status_in = STATUS_OK;
                        end else begin
                           // Good frame with payload: stream it out of the store.
                           ctl_in = CTL_READ;
                           idx_in = '0;
                        end
                     end
                     default: begin
                        phase_in = PH_HUNT;
                     end
                  endcase
               end
               if (load_out) begin
                  out_len_in    = '0;
                  out_data_in   = '0;
                  out_bvalid_in = 1'b0;
                  out_last_in   = 1'b1;
               end
            end
         end
         CTL_READ: begin
            mem_req.rd_en = 1'b1;
            ctl_in        = CTL_SEND;
         end
         CTL_SEND: begin
            // Read data stays in the store's register until the next read is issued.
            if (out_free) begin
               load_out      = 1'b1;
               out_status_in = STATUS_OK;
               out_len_in    = exp_len_ff;
               out_data_in   = mem_rd_data;
               out_bvalid_in = 1'b1;
               out_last_in   = (idx_inc == exp_len_ff);
               if (idx_inc == exp_len_ff) begin
                  ctl_in = CTL_ACCEPT;
               end else begin
                  idx_in = idx_inc[ADDR_W-1:0];
                  ctl_in = CTL_READ;
               end
            end
         end
         default: begin
            ctl_in = CTL_ACCEPT;
         end
      endcase

      out_valid_in = load_out || (out_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         ctl_ff       <= CTL_ACCEPT;
         exp_len_ff   <= '0;
         count_ff     <= '0;
         xor_ff       <= '0;
         timer_ff     <= '0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         ctl_ff       <= ctl_in;
         exp_len_ff   <= exp_len_in;
         count_ff     <= count_in;
         xor_ff       <= xor_in;
         timer_ff     <= timer_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_status_ff <= out_status_in;
      out_len_ff    <= out_len_in;
      out_data_ff   <= out_data_in;
      out_bvalid_ff <= out_bvalid_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.status       = out_status_ff;
   assign rsp.frame_length = out_len_ff;
   assign rsp.data_byte    = out_data_ff;
   assign rsp.byte_valid   = out_bvalid_ff;
   assign rsp.last         = out_last_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/sof_length_xor_frame_receiver.sv
// Top level of the SOF/length/XOR frame receiver: timeout CSR, parser and payload store.
// Depends on sfr_pkg, the channel interfaces, sfr_parser and sfr_store.
//
//   Channel   Role     Moves
//   req_chan  sink     one item: action (byte or tick) and rx_byte
//   rsp_chan  source   one result: status, frame_length, data_byte, byte_valid, last
//   csr_chan  sink     byte_timeout_ticks write data, always ready
//
// A byte or tick item that causes an error or empty-frame report leaves that report in
// the result register the cycle after it is taken. A good frame releases its payload
// bytes one at a time (store read, then result load, which waits while a result is not
// taken), the first byte after the checksum item; no item is taken meanwhile.
// The input stalls only while a result waits and is not taken, or during release.
// Reset is synchronous and returns the parser to hunting with the timeout at 100.
`default_nettype none

module sof_length_xor_frame_receiver (
   input  wire logic clock,
   input  wire logic reset,
   sfr_req_if.sink   req_chan,
   sfr_rsp_if.source rsp_chan,
   sfr_csr_if.sink   csr_chan
);
   import sfr_pkg::*;

   logic [CFG_W-1:0] timeout_ff, timeout_in;
   mem_req_type      mem_req;
   logic [7:0]       mem_rd_data;

   assign csr_chan.ready = 1'b1;
   assign timeout_in     = (csr_chan.valid && csr_chan.ready) ? csr_chan.wr_data : timeout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= CFG_RESET_TICKS;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   sfr_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .req           (req_chan),
      .rsp           (rsp_chan),
      .timeout_ticks (timeout_ff),
      .mem_req       (mem_req),
      .mem_rd_data   (mem_rd_data)
   );

   sfr_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

endmodule

`default_nettype wire

FILE: hw/rtl/sfr_checker.sv
// Port-level checks on the frame receiver's result channel, bound to the top level.
// Depends on sfr_pkg for status codes and the payload limit.
`default_nettype none

module sfr_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire logic [1:0]                rsp_status,
   input wire logic [sfr_pkg::LEN_W-1:0] rsp_frame_length,
   input wire logic [7:0]                rsp_data_byte,
   input wire logic                      rsp_byte_valid,
   input wire logic                      rsp_last
);
   import sfr_pkg::*;

   // A stalled result stays valid and keeps its data byte, status and last flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_byte)
                                  && $stable(rsp_status) && $stable(rsp_last))
      else $error("result changed while stalled");

   // Payload bytes only come from good frames.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_valid |-> rsp_status == STATUS_OK)
      else $error("payload byte with error status");

   // A report without a payload byte is always a single, final result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_last && rsp_frame_length == '0
                                       && rsp_data_byte == 8'd0)
      else $error("bare report not final or not cleared");

   // Released bytes carry a length within the store's size.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_valid |-> rsp_frame_length != '0
                                      && rsp_frame_length <= LEN_W'(MAX_PAYLOAD_BYTES))
      else $error("released byte with bad frame length");

endmodule

bind sof_length_xor_frame_receiver sfr_checker u_sfr_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_status       (rsp_chan.status),
   .rsp_frame_length (rsp_chan.frame_length),
   .rsp_data_byte    (rsp_chan.data_byte),
   .rsp_byte_valid   (rsp_chan.byte_valid),
   .rsp_last         (rsp_chan.last)
);

`default_nettype wire

FILE: bench/sfr_report_checker.sv
// Result checker for the SOF/length/XOR frame receiver: tracks the parser state,
// predicts every report and compares each accepted result with the oldest prediction.
// Depends on sfr_pkg for widths, limits and the status codes.

module sfr_report_checker
   import sfr_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_ready,
   input  wire logic               req_action,
   input  wire logic [7:0]         req_rx_byte,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_ready,
   input  wire logic [1:0]         rsp_status,
   input  wire logic [LEN_W-1:0]   rsp_frame_length,
   input  wire logic [7:0]         rsp_data_byte,
   input  wire logic               rsp_byte_valid,
   input  wire logic               rsp_last,
   input  wire logic               csr_valid,
   input  wire logic               csr_ready,
   input  wire logic [CFG_W-1:0]   csr_wr_data,
   output int unsigned             mismatch_count,
   output int unsigned             reports_pending,
   output int unsigned             results_checked,
   output int unsigned             good_frames,
   output int unsigned             error_reports,
   output logic                    parser_hunting
);

   typedef enum logic [1:0] {
      HUNT     = 2'd0,
      LENGTH   = 2'd1,
      PAYLOAD  = 2'd2,
      CHECKSUM = 2'd3
   } parse_phase_type;

   typedef struct packed {
      status_type       status;
      logic [LEN_W-1:0] frame_length;
      logic [7:0]       data_byte;
      logic             byte_valid;
      logic             last;
   } report_type;

   report_type         report_q[$];
   parse_phase_type    phase = HUNT;
   logic [LEN_W-1:0]   frame_len;
   logic [LEN_W-1:0]   bytes_seen;
   logic [7:0]         xor_sum;
   logic [TIMER_W-1:0] tick_count;
   logic [CFG_W-1:0]   timeout_ticks;
   logic [7:0]         payload_copy [MAX_PAYLOAD_BYTES];

   int unsigned        fail_total  = 0;
   int unsigned        result_total = 0;
   int unsigned        good_total  = 0;
   int unsigned        error_total = 0;

   task automatic goto_phase(input parse_phase_type next);
      phase      = next;
      tick_count = '0;
   endtask

   task automatic queue_report(input status_type st, input logic [LEN_W-1:0] len,
                               input logic [7:0] data, input logic valid,
                               input logic fin);
      report_type rep;
      rep.status       = st;
      rep.frame_length = len;
      rep.data_byte    = data;
      rep.byte_valid   = valid;
      rep.last         = fin;
      report_q.push_back(rep);
   endtask

   task automatic report_error(input status_type st);
      queue_report(st, '0, 8'h00, 1'b0, 1'b1);
      goto_phase(HUNT);
   endtask

   // One accepted item: either a millisecond tick or a received byte.
   task automatic parse_item(input logic is_tick, input logic [7:0] b);
      int unsigned limit;
      if (is_tick) begin
         limit = timeout_ticks;
         if (phase == PAYLOAD) limit = 32'(timeout_ticks) * 4;
         if (tick_count != TIMER_MAX) tick_count = tick_count + 1'b1;
         if (32'(tick_count) >= limit) report_error(STATUS_TIMEOUT);
      end else begin
         case (phase)
            HUNT: begin
               if (b != SOF_BYTE) report_error(STATUS_TIMEOUT);
               else goto_phase(LENGTH);
            end
            LENGTH: begin
               if (b > MAX_LEN_BYTE) report_error(STATUS_OVERFLOW);
               else begin
                  frame_len  = b[LEN_W-1:0];
                  bytes_seen = '0;
                  xor_sum    = 8'h00;
                  goto_phase(b == 8'h00 ? CHECKSUM : PAYLOAD);
               end
            end
            PAYLOAD: begin
               payload_copy[bytes_seen] = b;
               xor_sum    = xor_sum ^ b;
               bytes_seen = bytes_seen + 1'b1;
               // The payload timer spans the whole payload, so it only clears on leaving.
               if (bytes_seen >= frame_len) goto_phase(CHECKSUM);
            end
            default: begin
               if (b != xor_sum) report_error(STATUS_CHKERR);
               else begin
                  if (frame_len == '0) queue_report(STATUS_OK, '0, 8'h00, 1'b0, 1'b1);
                  for (int i = 0; i < int'(frame_len); i++)
                     queue_report(STATUS_OK, frame_len, payload_copy[i], 1'b1,
                                  (i + 1 == int'(frame_len)));
                  goto_phase(HUNT);
               end
            end
         endcase
      end
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_total++;
      end
   endtask

   always @(posedge clock) begin : watch
      report_type want;
      if (reset) begin
         report_q.delete();
         frame_len     = '0;
         bytes_seen    = '0;
         xor_sum       = 8'h00;
         timeout_ticks = CFG_RESET_TICKS;
         goto_phase(HUNT);
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (report_q.size() == 0) begin
               $error("unexpected result: status %0d, frame_length %0d, data_byte %0d",
                      rsp_status, rsp_frame_length, rsp_data_byte);
               fail_total++;
            end else begin
               want = report_q.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("frame_length", want.frame_length, rsp_frame_length);
               check_field("data_byte", want.data_byte, rsp_data_byte);
               check_field("byte_valid", want.byte_valid, rsp_byte_valid);
               check_field("last", want.last, rsp_last);
               result_total++;
               if (want.status != STATUS_OK) error_total++;
               else if (want.last) good_total++;
            end
         end
         if (csr_valid && csr_ready) timeout_ticks = csr_wr_data;
         if (req_valid && req_ready) parse_item(req_action, req_rx_byte);
      end
      mismatch_count  <= fail_total;
      reports_pending <= report_q.size();
      results_checked <= result_total;
      good_frames     <= good_total;
      error_reports   <= error_total;
      parser_hunting  <= (phase == HUNT);
   end

endmodule

FILE: bench/tb.sv
// Testbench top for the SOF/length/XOR frame receiver: clock, reset, stimulus and verdict.
// Depends on sfr_pkg, the channel interfaces, the block itself and sfr_report_checker.

module tb;
   import sfr_pkg::*;

   localparam int unsigned CYCLE_LIMIT      = 1_000_000;
   localparam int unsigned DRAIN_CYCLES     = 12;
   localparam int unsigned ITEMS_PER_SETTING = 20;

   logic        clock;
   logic        reset;
   int unsigned items_sent    = 0;
   int unsigned settings_used = 1;
   int unsigned cycle_count   = 0;
   bit          gaps_on       = 1'b1;
   int unsigned tick_pct      = 10;

   int unsigned mismatch_count;
   int unsigned reports_pending;
   int unsigned results_checked;
   int unsigned good_frames;
   int unsigned error_reports;
   logic        parser_hunting;

   sfr_req_if req_chan ();
   sfr_rsp_if rsp_chan ();
   sfr_csr_if csr_chan ();

   sof_length_xor_frame_receiver u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   sfr_report_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_chan.valid),
      .req_ready        (req_chan.ready),
      .req_action       (req_chan.action),
      .req_rx_byte      (req_chan.rx_byte),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_status       (rsp_chan.status),
      .rsp_frame_length (rsp_chan.frame_length),
      .rsp_data_byte    (rsp_chan.data_byte),
      .rsp_byte_valid   (rsp_chan.byte_valid),
      .rsp_last         (rsp_chan.last),
      .csr_valid        (csr_chan.valid),
      .csr_ready        (csr_chan.ready),
      .csr_wr_data      (csr_chan.wr_data),
      .mismatch_count   (mismatch_count),
      .reports_pending  (reports_pending),
      .results_checked  (results_checked),
      .good_frames      (good_frames),
      .error_reports    (error_reports),
      .parser_hunting   (parser_hunting)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("sof_length_xor_frame_receiver regression: fail");
      $finish;
   end

   // Result side backpressure: mostly long ready stretches, short stalls, a few long ones.
   initial begin : rsp_pacing
      int unsigned hold;
      int unsigned pick;
      rsp_chan.ready <= 1'b0;
      hold = 0;
      forever begin
         @(posedge clock);
         if (hold > 0) hold--;
         else begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
               rsp_chan.ready <= 1'b1;
               hold = $urandom_range(0, 30);
            end else if (pick < 95) begin
               rsp_chan.ready <= 1'b0;
               hold = $urandom_range(0, 3);
            end else begin
               rsp_chan.ready <= 1'b0;
               hold = $urandom_range(20, 60);
            end
         end
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic int unsigned pick_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 85) return $urandom_range(0, 6);
      if (r < 95) return $urandom_range(7, MAX_PAYLOAD_BYTES - 1);
      return MAX_PAYLOAD_BYTES;
   endfunction

   // Returns at the edge that accepted the item, with valid still high.
   task automatic send_item(input logic act, input logic [7:0] b);
      int unsigned idle;
      idle = gaps_on ? pick_gap() : 0;
      if (idle > 0) begin
         req_chan.valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.action  <= act;
      req_chan.rx_byte <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_item(1'b0, b);
   endtask

   task automatic send_tick();
      send_item(1'b1, 8'($urandom));
   endtask

   task automatic send_frame_byte(input logic [7:0] b);
      if ($urandom_range(0, 99) < tick_pct) repeat ($urandom_range(1, 3)) send_tick();
      send_byte(b);
   endtask

   // A cut frame stops somewhere in its payload and never sends a checksum.
   task automatic send_frame(input int unsigned len, input bit bad_chk, input bit cut);
      logic [7:0]  sum;
      logic [7:0]  b;
      int unsigned n;
      n   = cut ? $urandom_range(0, len) : len;
      sum = 8'h00;
      send_frame_byte(SOF_BYTE);
      send_frame_byte(8'(len));
      for (int unsigned i = 0; i < n; i++) begin
         b   = 8'($urandom);
         sum = sum ^ b;
         send_frame_byte(b);
      end
      if (!cut) send_frame_byte(bad_chk ? sum ^ 8'($urandom_range(1, 255)) : sum);
   endtask

   // The last item stays on the channel after its accept, so it is withdrawn first.
   task automatic settle();
      req_chan.valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (reports_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Pushes the parser back to hunting; a stray byte ends any phase eventually.
   task automatic resync();
      settle();
      while (!parser_hunting) begin
         send_byte(8'h1F);
         settle();
      end
   endtask

   task automatic csr_write(input logic [CFG_W-1:0] value);
      csr_chan.valid   <= 1'b1;
      csr_chan.wr_data <= value;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.valid <= 1'b0;
      settings_used++;
   endtask

   task automatic random_traffic(input int unsigned count);
      int unsigned stop_at;
      int unsigned kind;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 9) == 0) gaps_on = ($urandom_range(0, 3) != 0);
         kind = $urandom_range(0, 99);
         if (kind < 55) send_frame(pick_length(), 1'b0, 1'b0);
         else if (kind < 67) send_frame(pick_length(), 1'b1, 1'b0);
         else if (kind < 75) begin
            send_frame_byte(SOF_BYTE);
            send_frame_byte(8'($urandom_range(MAX_PAYLOAD_BYTES + 1, 255)));
         end else if (kind < 85) send_byte(8'($urandom));
         else if (kind < 95) repeat ($urandom_range(1, 12)) send_tick();
         else send_frame($urandom_range(1, MAX_PAYLOAD_BYTES), 1'b0, 1'b1);
      end
      gaps_on = 1'b1;
   endtask

   initial begin : stimulus
      int unsigned small_cfg;
      req_chan.valid   <= 1'b0;
      req_chan.action  <= 1'b0;
      req_chan.rx_byte <= 8'h00;
      csr_chan.valid   <= 1'b0;
      csr_chan.wr_data <= '0;
      reset            <= 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      settle();

      // Reset timeout value: bad starts, empty frames, overflows, checksum cases.
      send_byte(8'h00);
      send_byte(8'hFF);
      send_tick();
      send_tick();
      send_byte(SOF_BYTE); send_byte(8'h00); send_byte(8'h00);
      send_byte(SOF_BYTE); send_byte(8'h00); send_byte(8'h5A);
      send_byte(SOF_BYTE); send_byte(MAX_LEN_BYTE + 8'd1);
      send_byte(SOF_BYTE); send_byte(8'hFF);
      send_byte(SOF_BYTE); send_byte(8'h01); send_byte(8'hFF); send_byte(8'hFF);
      send_byte(SOF_BYTE); send_byte(8'h02); send_byte(8'h12); send_byte(8'h34);
      send_byte(8'h00);
      send_frame(MAX_PAYLOAD_BYTES, 1'b0, 1'b0);
      random_traffic(ITEMS_PER_SETTING);

      // Largest timeout: ticks scattered through the traffic never expire a phase.
      settle();
      csr_write(16'hFFFF);
      resync();
      random_traffic(ITEMS_PER_SETTING);

      // A zero timeout makes the first tick of every phase expire.
      settle();
      csr_write(16'h0000);
      random_traffic(ITEMS_PER_SETTING);

      settle();
      csr_write(16'h0001);
      random_traffic(ITEMS_PER_SETTING);

      // Small timeout: expire each phase on purpose, the payload after four times the limit.
      small_cfg = $urandom_range(2, 12);
      settle();
      csr_write(CFG_W'(small_cfg));
      resync();
      repeat (small_cfg) send_tick();
      send_byte(SOF_BYTE);
      repeat (small_cfg) send_tick();
      send_byte(SOF_BYTE); send_byte(8'h03); send_byte(8'h11);
      repeat (4 * small_cfg) send_tick();
      send_byte(SOF_BYTE); send_byte(8'h00);
      repeat (small_cfg) send_tick();
      random_traffic(ITEMS_PER_SETTING);

      req_chan.valid <= 1'b0;
      settle();

      $display("Sent %0d items over %0d timeout settings; checked %0d results.",
               items_sent, settings_used, results_checked);
      $display("Reports seen: %0d good frames and %0d error reports.",
               good_frames, error_reports);
      if (mismatch_count == 0) begin
         $display("sof_length_xor_frame_receiver regression: pass");
      end else begin
         $display("sof_length_xor_frame_receiver regression: fail");
      end
      $finish;
   end

endmodule
